/* rtl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants, codes and types of the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

   localparam int STORE_DEPTH = 128;
   localparam int KEY_WIDTH   = 32;
   localparam int ADDR_WIDTH  = $clog2(STORE_DEPTH);
   localparam int COUNT_WIDTH = ADDR_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] CAPACITY  = COUNT_WIDTH'(STORE_DEPTH - 1);
   localparam logic [ADDR_WIDTH-1:0]  ROOT_ADDR = ADDR_WIDTH'(1);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                  we;
      logic [ADDR_WIDTH-1:0] waddr;
      logic [KEY_WIDTH-1:0]  wdata;
      logic [ADDR_WIDTH-1:0] raddr_a;
      logic [ADDR_WIDTH-1:0] raddr_b;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [KEY_WIDTH-1:0]   removed_key;
      logic [COUNT_WIDTH-1:0] entry_count;
      logic [KEY_WIDTH-1:0]   top_key;
   } result_type;

   function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                     input logic [KEY_WIDTH-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

endpackage

`default_nettype wire

/* rtl/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed keys with insert and remove-maximum requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready): req_kind selects insert of
//   req_key_in or removal of the maximum. Response channel
//   (rsp_valid/rsp_ready): one transfer per request carrying rsp_status,
//   rsp_removed_key, rsp_entry_count and rsp_top_key.
//   Keys live in a 128-entry RAM with one write and two read ports; entry 0
//   is unused, so up to 127 keys are held.
//   Each heap level takes a RAM read, then a compare and write-back.
//   An insert climbs from the new leaf until the key reaches the root or
//   meets a parent that is not smaller. A remove reads the last entry and,
//   unless that empties the heap, sifts it down from the root until it
//   settles in a leaf or no child is larger. Rejected requests (remove on
//   empty, insert on full) respond without touching the RAM.
//   One request is in flight at a time; the next is taken once the result
//   sits in the output register, even while the receiver stalls it. A second
//   result waits in the engine until the output register drains.
//   Reset empties the heap and clears the output valid; RAM contents are
//   left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_kind,
   input  wire logic signed [mhpq_pkg::KEY_WIDTH-1:0]  req_key_in,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic             [1:0]                      rsp_status,
   output logic signed      [mhpq_pkg::KEY_WIDTH-1:0]  rsp_removed_key,
   output logic             [mhpq_pkg::COUNT_WIDTH-1:0] rsp_entry_count,
   output logic signed      [mhpq_pkg::KEY_WIDTH-1:0]  rsp_top_key
);

   mhpq_pkg::mem_req_type            mem;
   mhpq_pkg::result_type             res;
   logic                             res_valid;
   logic                             res_ready;
   logic [mhpq_pkg::KEY_WIDTH-1:0]   rd_a;
   logic [mhpq_pkg::KEY_WIDTH-1:0]   rd_b;

   logic                             rsp_valid_ff;
   mhpq_pkg::result_type             rsp_data_ff;

   mhpq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_key_in (req_key_in),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .mem        (mem),
      .rd_a       (rd_a),
      .rd_b       (rd_b)
   );

   mhpq_ram #(
      .WIDTH (mhpq_pkg::KEY_WIDTH),
      .DEPTH (mhpq_pkg::STORE_DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .we      (mem.we),
      .waddr   (mem.waddr),
      .wdata   (mem.wdata),
      .raddr_a (mem.raddr_a),
      .raddr_b (mem.raddr_b),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_removed_key = rsp_data_ff.removed_key;
   assign rsp_entry_count = rsp_data_ff.entry_count;
   assign rsp_top_key     = rsp_data_ff.top_key;

endmodule

`default_nettype wire

/* rtl/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

/* rtl/mhpq_engine.sv */
// ----------------------------------------------------------------------------
// mhpq_engine
// Heap sequencer: holds the fill count and the root, walks sift-up and
// sift-down one level per read/compare pair against the heap RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_engine (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_kind,
   input  wire logic [mhpq_pkg::KEY_WIDTH-1:0]   req_key_in,
   output logic                                  res_valid,
   input  wire logic                             res_ready,
   output mhpq_pkg::result_type                  res,
   output mhpq_pkg::mem_req_type                 mem,
   input  wire logic [mhpq_pkg::KEY_WIDTH-1:0]   rd_a,
   input  wire logic [mhpq_pkg::KEY_WIDTH-1:0]   rd_b
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_CMP,
      S_RM_READ,
      S_RM_LOAD,
      S_DN_READ,
      S_DN_CMP,
      S_DONE
   } state_type;

   state_type                            state_ff, state_in;
   logic [mhpq_pkg::COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [mhpq_pkg::ADDR_WIDTH-1:0]      idx_ff, idx_in;
   logic [mhpq_pkg::KEY_WIDTH-1:0]       hole_ff, hole_in;
   logic [mhpq_pkg::KEY_WIDTH-1:0]       top_ff, top_in;
   logic [mhpq_pkg::KEY_WIDTH-1:0]       removed_ff, removed_in;
   logic [1:0]                           status_ff, status_in;

   logic [mhpq_pkg::ADDR_WIDTH:0]        left_child;
   logic [mhpq_pkg::ADDR_WIDTH:0]        right_child;
   logic [mhpq_pkg::ADDR_WIDTH:0]        count_ext;
   logic                                 right_ok;
   logic                                 pick_right;
   logic [mhpq_pkg::KEY_WIDTH-1:0]       pick_key;
   logic [mhpq_pkg::ADDR_WIDTH-1:0]      pick_addr;
   logic [mhpq_pkg::ADDR_WIDTH-1:0]      parent_addr;

   assign left_child  = {idx_ff, 1'b0};
   assign right_child = left_child + (mhpq_pkg::ADDR_WIDTH + 1)'(1);
   assign count_ext   = {1'b0, count_ff};
   assign right_ok    = right_child <= count_ext;
   assign pick_right  = right_ok && mhpq_pkg::key_less(rd_a, rd_b);
   assign pick_key    = pick_right ? rd_b : rd_a;
   assign pick_addr   = pick_right ? right_child[mhpq_pkg::ADDR_WIDTH-1:0]
                                   : left_child[mhpq_pkg::ADDR_WIDTH-1:0];
   assign parent_addr = idx_ff >> 1;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      hole_in     = hole_ff;
      removed_in  = removed_ff;
      status_in   = status_ff;
      mem         = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               removed_in = '0;
               status_in  = mhpq_pkg::STATUS_DONE;
               if (req_kind == mhpq_pkg::KIND_INSERT) begin
                  if (count_ff == mhpq_pkg::CAPACITY) begin
                     status_in = mhpq_pkg::STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     count_in = count_ff + mhpq_pkg::COUNT_WIDTH'(1);
                     idx_in   = count_ff + mhpq_pkg::ADDR_WIDTH'(1);
                     hole_in  = req_key_in;
                     state_in = S_UP_READ;
                  end
               end else if (count_ff == '0) begin
                  status_in = mhpq_pkg::STATUS_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  removed_in = top_ff;
                  state_in   = S_RM_READ;
               end
            end
         end
         S_UP_READ: begin
            if (idx_ff == mhpq_pkg::ROOT_ADDR) begin
               mem.we    = 1'b1;
               mem.waddr = idx_ff;
               mem.wdata = hole_ff;
               state_in  = S_DONE;
            end else begin
               mem.raddr_a = parent_addr;
               state_in    = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem.we    = 1'b1;
            mem.waddr = idx_ff;
            if (mhpq_pkg::key_less(rd_a, hole_ff)) begin
               mem.wdata = rd_a;
               idx_in    = parent_addr;
               state_in  = S_UP_READ;
            end else begin
               mem.wdata = hole_ff;
               state_in  = S_DONE;
            end
         end
         S_RM_READ: begin
            mem.raddr_a = count_ff;
            state_in    = S_RM_LOAD;
         end
         S_RM_LOAD: begin
            hole_in  = rd_a;
            count_in = count_ff - mhpq_pkg::COUNT_WIDTH'(1);
            idx_in   = mhpq_pkg::ROOT_ADDR;
            state_in = (count_ff == mhpq_pkg::COUNT_WIDTH'(1)) ? S_DONE : S_DN_READ;
         end
         S_DN_READ: begin
            if (left_child > count_ext) begin
               mem.we    = 1'b1;
               mem.waddr = idx_ff;
               mem.wdata = hole_ff;
               state_in  = S_DONE;
            end else begin
               mem.raddr_a = left_child[mhpq_pkg::ADDR_WIDTH-1:0];
               mem.raddr_b = right_child[mhpq_pkg::ADDR_WIDTH-1:0];
               state_in    = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            mem.we    = 1'b1;
            mem.waddr = idx_ff;
            if (mhpq_pkg::key_less(hole_ff, pick_key)) begin
               mem.wdata = pick_key;
               idx_in    = pick_addr;
               state_in  = S_DN_READ;
            end else begin
               mem.wdata = hole_ff;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      top_in = (mem.we && mem.waddr == mhpq_pkg::ROOT_ADDR) ? mem.wdata : top_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff     <= idx_in;
      hole_ff    <= hole_in;
      top_ff     <= top_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   assign req_ready       = state_ff == S_IDLE;
   assign res_valid       = state_ff == S_DONE;
   assign res.status      = status_ff;
   assign res.removed_key = removed_ff;
   assign res.entry_count = count_ff;
   assign res.top_key     = (count_ff == '0) ? '0 : top_ff;

endmodule

`default_nettype wire

/* rtl/mhpq_checker.sv */
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks of the max-heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [1:0]                       rsp_status,
   input wire logic [mhpq_pkg::KEY_WIDTH-1:0]   rsp_removed_key,
   input wire logic [mhpq_pkg::COUNT_WIDTH-1:0] rsp_entry_count,
   input wire logic [mhpq_pkg::KEY_WIDTH-1:0]   rsp_top_key
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_removed_key)
         && $stable(rsp_status) && $stable(rsp_entry_count) && $stable(rsp_top_key))
      else $error("response changed while stalled");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count == '0 |-> rsp_top_key == '0)
      else $error("top key not zero on empty heap");

   a_reject_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mhpq_pkg::STATUS_DONE |-> rsp_removed_key == '0)
      else $error("rejected request returned a key");

   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::STATUS_EMPTY |-> rsp_entry_count == '0)
      else $error("empty status with keys held");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::STATUS_FULL
         |-> rsp_entry_count == mhpq_pkg::CAPACITY)
      else $error("full status below capacity");

endmodule

bind max_heap_priority_queue mhpq_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_removed_key (rsp_removed_key),
   .rsp_entry_count (rsp_entry_count),
   .rsp_top_key     (rsp_top_key)
);

`default_nettype wire
